FILE: hw/rtl/slc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slc_pkg;

	// Linear light and normalized tristimulus values, unsigned Q1.16 (0..65536).
	localparam int LinW = 17;
	// CIELAB components in Q16, signed.
	localparam int LabW = 27;
	localparam int DiffW = LabW + 1;
	localparam int SqW = 2 * (DiffW - 1);
	localparam int SumW = SqW + 2;
	localparam int RootW = SumW / 2;

	localparam int LaneStages = 6;
	localparam int MergeStages = 3 + RootW + 1;
	localparam int Latency = LaneStages + MergeStages;

	typedef logic [255:0][LinW-1:0] lin_tab_t;

	typedef struct packed {
		logic signed [LabW-1:0] l;
		logic signed [LabW-1:0] a;
		logic signed [LabW-1:0] b;
	} lab_t;

	// sRGB transfer curve: linear segment near black, 2.4 power above it.
	function automatic lin_tab_t build_lin_tab();
		lin_tab_t tab;
		real t;
		for (int c = 0; c < 256; c++) begin
			if (c <= 10) begin
				tab[c] = LinW'((c * 6553600) / 329460);
			end else begin
				t = (1000.0 * c + 14025.0) / 269025.0;
				tab[c] = LinW'($rtoi(65536.0 * (t ** 2.4)));
			end
		end
		return tab;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/slc_lab_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module slc_lab_lane #(
	parameter int CUBE_ROOT_TABLE_BITS = 10
) (
	input  logic          clk,
	input  logic [7:0]    red,
	input  logic [7:0]    green,
	input  logic [7:0]    blue,
	output slc_pkg::lab_t lab
);
	import slc_pkg::*;

	localparam int Cb = CUBE_ROOT_TABLE_BITS;
	localparam int FrW = 16 - Cb;
	localparam int Entries = (1 << Cb) + 1;
	localparam int ProdW = LinW + 16;
	localparam int MixW = LinW + 18;
	// floor(7787 * v / 1000) equals (v * SlopeMul) >> 20 for every v up to 580.
	localparam logic [22:0] SlopeMul = 23'd8165262;

	typedef logic [Entries-1:0][LinW-1:0] cbrt_tab_t;

	function automatic cbrt_tab_t build_cbrt_tab();
		cbrt_tab_t tab;
		logic [63:0] n, lo, hi, mid;
		for (int i = 0; i < Entries; i++) begin
			n = 64'(i) << (48 - Cb);
			lo = 64'd0;
			hi = 64'd65536;
			for (int k = 0; k < 18; k++) begin
				if (lo < hi) begin
					mid = (lo + hi + 64'd1) >> 1;
					if (mid * mid * mid <= n) lo = mid;
					else hi = mid - 64'd1;
				end
			end
			tab[i] = LinW'(lo);
		end
		return tab;
	endfunction

	localparam lin_tab_t LinTab = build_lin_tab();
	localparam cbrt_tab_t CbrtTab = build_cbrt_tab();

	// Rows give X, Y and Z with the D65 white already divided out.
	localparam logic [15:0] Coef [3][3] = '{
		'{16'd28440, 16'd24655, 16'd12441},
		'{16'd13938, 16'd46868, 16'd4730},
		'{16'd1164,  16'd7174,  16'd57198}
	};

	localparam logic signed [LabW-1:0] K116 = 116;
	localparam logic signed [LabW-1:0] K500 = 500;
	localparam logic signed [LabW-1:0] K200 = 200;
	localparam logic signed [LabW-1:0] Off16 = 1048576;

	logic [LinW-1:0]  lin_s1 [3];
	logic [ProdW-1:0] prod_s2 [3][3];
	logic [LinW-1:0]  v_s3 [3];
	logic             small_s4 [3];
	logic [9:0]       vlow_s4 [3];
	logic [LinW-1:0]  e0_s4 [3];
	logic [LinW-1:0]  de_s4 [3];
	logic [FrW-1:0]   fr_s4 [3];
	logic [LinW-1:0]  f_s5 [3];
	lab_t             lab_s6;

	always_ff @(posedge clk) begin
		lin_s1[0] <= LinTab[red];
		lin_s1[1] <= LinTab[green];
		lin_s1[2] <= LinTab[blue];
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_s2[r][c] <= ProdW'(Coef[r][c]) * ProdW'(lin_s1[c]);
			end
		end
	end

	logic [MixW-1:0] mix_sum [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			mix_sum[r] = MixW'(prod_s2[r][0]) + MixW'(prod_s2[r][1])
				+ MixW'(prod_s2[r][2]) + MixW'(32768);
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			v_s3[r] <= mix_sum[r][LinW+15:16];
		end
	end

	logic [Cb:0]     idx [3];
	logic [LinW-1:0] e0 [3];
	logic [LinW-1:0] e1 [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			idx[r] = v_s3[r][LinW-1:FrW];
			if (idx[r][Cb]) begin
				e0[r] = CbrtTab[Entries-1];
				e1[r] = CbrtTab[Entries-1];
			end else begin
				e0[r] = CbrtTab[idx[r]];
				e1[r] = CbrtTab[idx[r] + 1'b1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			small_s4[r] <= (v_s3[r] <= LinW'(580));
			vlow_s4[r] <= v_s3[r][9:0];
			e0_s4[r] <= e0[r];
			de_s4[r] <= e1[r] - e0[r];
			fr_s4[r] <= v_s3[r][FrW-1:0];
		end
	end

	logic [32:0]         lin_prod [3];
	logic [LinW+FrW-1:0] int_prod [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			lin_prod[r] = 33'(vlow_s4[r]) * 33'(SlopeMul);
			int_prod[r] = (LinW + FrW)'(de_s4[r]) * (LinW + FrW)'(fr_s4[r]);
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			if (small_s4[r]) f_s5[r] <= LinW'(lin_prod[r] >> 20) + LinW'(9039);
			else f_s5[r] <= e0_s4[r] + LinW'(int_prod[r] >> FrW);
		end
	end

	logic signed [LabW-1:0] fx, fy, fz;

	always_comb begin
		fx = LabW'(f_s5[0]);
		fy = LabW'(f_s5[1]);
		fz = LabW'(f_s5[2]);
	end

	always_ff @(posedge clk) begin
		lab_s6.l <= fy * K116 - Off16;
		lab_s6.a <= (fx - fy) * K500;
		lab_s6.b <= (fy - fz) * K200;
	end

	assign lab = lab_s6;

endmodule

`default_nettype wire

FILE: hw/rtl/slc_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Digit-by-digit square root, one root bit per pipeline stage.
module slc_isqrt #(
	parameter int SIDE_W = 8
) (
	input  logic                     clk,
	input  logic [slc_pkg::SumW-1:0] radicand,
	input  logic [SIDE_W-1:0]        side_in,
	output logic [slc_pkg::RootW-1:0] root,
	output logic [SIDE_W-1:0]        side_out
);
	import slc_pkg::*;

	localparam int RemW = RootW + 2;

	logic [RemW-1:0]   rem_s  [RootW+1];
	logic [RootW-1:0]  root_s [RootW+1];
	logic [SumW-1:0]   rad_s  [RootW+1];
	logic [SIDE_W-1:0] side_s [RootW+1];

	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign rad_s[0] = radicand;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < RootW; i++) begin : g_stage
		logic [RemW-1:0] rem_n, trial;

		always_comb begin
			rem_n = {rem_s[i][RemW-3:0], rad_s[i][SumW-1:SumW-2]};
			trial = {root_s[i], 2'b01};
		end

		always_ff @(posedge clk) begin
			if (rem_n >= trial) begin
				rem_s[i+1] <= rem_n - trial;
				root_s[i+1] <= {root_s[i][RootW-2:0], 1'b1};
			end else begin
				rem_s[i+1] <= rem_n;
				root_s[i+1] <= {root_s[i][RootW-2:0], 1'b0};
			end
			rad_s[i+1] <= {rad_s[i][SumW-3:0], 2'b00};
			side_s[i+1] <= side_s[i];
		end
	end

	assign root = root_s[RootW];
	assign side_out = side_s[RootW];

endmodule

`default_nettype wire

FILE: hw/rtl/slc_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module slc_merge #(
	parameter int FRACTION_BITS = 8
) (
	input  logic               clk,
	input  slc_pkg::lab_t      lab_first,
	input  slc_pkg::lab_t      lab_second,
	output logic [14:0]        lightness,
	output logic signed [15:0] green_red,
	output logic signed [15:0] blue_yellow,
	output logic [16:0]        distance
);
	import slc_pkg::*;

	localparam int Sh = 16 - FRACTION_BITS;
	localparam logic [DiffW:0] Half = (DiffW + 1)'((64'd1 << Sh) >> 1);
	localparam int SideW = 15 + 16 + 16;

	function automatic logic [DiffW:0] round_mag(input logic [DiffW-1:0] m);
		logic [DiffW:0] s;
		s = {1'b0, m} + Half;
		return s >> Sh;
	endfunction

	function automatic logic [DiffW:0] round_abs(input logic signed [LabW-1:0] x);
		logic signed [DiffW-1:0] w;
		w = DiffW'(x);
		return round_mag(x[LabW-1] ? (DiffW - 1)'(-w) : (DiffW - 1)'(w));
	endfunction

	function automatic logic [15:0] sat_signed(input logic signed [LabW-1:0] x);
		logic [DiffW:0] r;
		r = round_abs(x);
		if (x[LabW-1]) return (r > 32768) ? 16'h8000 : 16'(~r[15:0] + 16'd1);
		else return (r > 32767) ? 16'h7fff : r[15:0];
	endfunction

	function automatic logic [14:0] sat_light(input logic signed [LabW-1:0] x);
		logic [DiffW:0] r;
		r = round_abs(x);
		if (x[LabW-1]) return 15'd0;
		else return (r > 32767) ? 15'h7fff : r[14:0];
	endfunction

	logic signed [DiffW-1:0] d_s1 [3];
	logic [SideW-1:0]        side_s1;

	always_ff @(posedge clk) begin
		d_s1[0] <= DiffW'(lab_first.l) - DiffW'(lab_second.l);
		d_s1[1] <= DiffW'(lab_first.a) - DiffW'(lab_second.a);
		d_s1[2] <= DiffW'(lab_first.b) - DiffW'(lab_second.b);
		side_s1 <= {sat_light(lab_first.l), sat_signed(lab_first.a), sat_signed(lab_first.b)};
	end

	logic [DiffW-2:0] mag [3];
	logic [SqW-1:0]   sq_s2 [3];
	logic [SideW-1:0] side_s2;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mag[k] = d_s1[k][DiffW-1] ? (DiffW - 1)'(-d_s1[k]) : (DiffW - 1)'(d_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sq_s2[k] <= SqW'(mag[k]) * SqW'(mag[k]);
		end
		side_s2 <= side_s1;
	end

	logic [SumW-1:0]  sum_s3;
	logic [SideW-1:0] side_s3;

	always_ff @(posedge clk) begin
		sum_s3 <= SumW'(sq_s2[0]) + SumW'(sq_s2[1]) + SumW'(sq_s2[2]);
		side_s3 <= side_s2;
	end

	logic [RootW-1:0] root;
	logic [SideW-1:0] side_rt;

	slc_isqrt #(
		.SIDE_W(SideW)
	) u_isqrt (
		.clk      (clk),
		.radicand (sum_s3),
		.side_in  (side_s3),
		.root     (root),
		.side_out (side_rt)
	);

	logic [DiffW:0] root_rnd;
	assign root_rnd = round_mag((DiffW - 1)'(root));

	logic [SideW-1:0] side_q;
	logic [16:0]      dist_q;

	always_ff @(posedge clk) begin
		dist_q <= (root_rnd > 131071) ? 17'h1ffff : root_rnd[16:0];
		side_q <= side_rt;
	end

	assign lightness = side_q[SideW-1:32];
	assign green_red = side_q[31:16];
	assign blue_yellow = side_q[15:0];
	assign distance = dist_q;

endmodule

`default_nettype wire

FILE: hw/rtl/srgb_lab_color_distance.sv
`timescale 1ns / 1ps
`default_nettype none

// done marks the cycle in which the results of an accepted item are on the outputs.
// Throughput: one item per cycle; busy stays low, so start may be held high.
// The Lab lanes feed the 28-stage square-root pipeline.
// Results are not held: each is shown for one cycle with done and the receiver cannot stall.
// Reset (arst_n low) clears all item valid flags at once; the tables are constants.
module srgb_lab_color_distance #(
	parameter int FRACTION_BITS = 8,
	parameter int CUBE_ROOT_TABLE_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [7:0]         red_first,
	input  logic [7:0]         green_first,
	input  logic [7:0]         blue_first,
	input  logic [7:0]         red_second,
	input  logic [7:0]         green_second,
	input  logic [7:0]         blue_second,
	output logic               done,
	output logic [14:0]        lightness_first,
	output logic signed [15:0] green_red_axis_first,
	output logic signed [15:0] blue_yellow_axis_first,
	output logic [16:0]        distance
);
	import slc_pkg::*;

	lab_t lab_first, lab_second;
	logic [Latency-1:0] vld_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[Latency-2:0], start & ~busy};
		end
	end

	assign done = vld_q[Latency-1];

	slc_lab_lane #(
		.CUBE_ROOT_TABLE_BITS(CUBE_ROOT_TABLE_BITS)
	) u_lane_first (
		.clk   (clk),
		.red   (red_first),
		.green (green_first),
		.blue  (blue_first),
		.lab   (lab_first)
	);

	slc_lab_lane #(
		.CUBE_ROOT_TABLE_BITS(CUBE_ROOT_TABLE_BITS)
	) u_lane_second (
		.clk   (clk),
		.red   (red_second),
		.green (green_second),
		.blue  (blue_second),
		.lab   (lab_second)
	);

	slc_merge #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_merge (
		.clk         (clk),
		.lab_first   (lab_first),
		.lab_second  (lab_second),
		.lightness   (lightness_first),
		.green_red   (green_red_axis_first),
		.blue_yellow (blue_yellow_axis_first),
		.distance    (distance)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/slc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module slc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [7:0]  red_first,
	input logic [7:0]  green_first,
	input logic [7:0]  blue_first,
	input logic [7:0]  red_second,
	input logic [7:0]  green_second,
	input logic [7:0]  blue_second,
	input logic        done,
	input logic [16:0] distance
);
	import slc_pkg::*;

	// The block never refuses an item.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##Latency done)
		else $error("accepted item produced no result");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, Latency))
		else $error("result without an accepted item");

	// Two equal colors must be zero apart.
	a_same_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && red_first == red_second && green_first == green_second
			&& blue_first == blue_second) |-> ##Latency (distance == 17'd0))
		else $error("nonzero distance for equal colors");

endmodule

bind srgb_lab_color_distance slc_checker u_slc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.red_first    (red_first),
	.green_first  (green_first),
	.blue_first   (blue_first),
	.red_second   (red_second),
	.green_second (green_second),
	.blue_second  (blue_second),
	.done         (done),
	.distance     (distance)
);

`default_nettype wire

FILE: verif/srgb_lab_color_distance_checker.sv
`timescale 1ns / 1ps

module srgb_lab_color_distance_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [7:0]         red_first,
	input  logic [7:0]         green_first,
	input  logic [7:0]         blue_first,
	input  logic [7:0]         red_second,
	input  logic [7:0]         green_second,
	input  logic [7:0]         blue_second,
	input  logic               done,
	input  logic [14:0]        lightness_first,
	input  logic signed [15:0] green_red_axis_first,
	input  logic signed [15:0] blue_yellow_axis_first,
	input  logic [16:0]        distance,
	output int                 fail_count,
	output int                 open_count
);

	localparam int CubeBits = 10;
	localparam int CubeEntries = (1 << CubeBits) + 1;
	localparam int FracShift = 16 - 8;

	typedef struct packed {
		logic [14:0] lightness;
		logic [15:0] green_red;
		logic [15:0] blue_yellow;
		logic [16:0] span;
	} color_result_t;

	longint unsigned linear_light[256];
	longint unsigned cube_root_tab[CubeEntries];
	color_result_t expected_colors[$];

	// Exact floor of 65536 * (num / 269025)^2.4, compared in fifth powers.
	function automatic longint unsigned gamma_floor(input int c);
		logic [383:0] num_pow, mid_pow;
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 65536;
		num_pow = 1;
		for (int i = 0; i < 12; i++) num_pow = num_pow * (1000 * c + 14025);
		num_pow = num_pow << 80;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			mid_pow = 1;
			for (int i = 0; i < 5; i++) mid_pow = mid_pow * mid;
			for (int i = 0; i < 12; i++) mid_pow = mid_pow * 269025;
			if (mid_pow <= num_pow) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic longint unsigned cube_root_floor(input longint unsigned n);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 65536;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid * mid <= n) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic longint lab_curve(input longint unsigned v);
		longint unsigned idx, frac, e0, e1;
		if (v <= 580) return (7787 * v) / 1000 + 9039;
		idx = v >> (16 - CubeBits);
		if (idx >= (1 << CubeBits)) return cube_root_tab[1 << CubeBits];
		frac = v & ((1 << (16 - CubeBits)) - 1);
		e0 = cube_root_tab[idx];
		e1 = cube_root_tab[idx + 1];
		return e0 + (((e1 - e0) * frac) >> (16 - CubeBits));
	endfunction

	function automatic longint unsigned tristimulus(input longint unsigned k0, k1, k2,
			input longint unsigned r, g, b);
		return (k0 * r + k1 * g + k2 * b + 32768) >> 16;
	endfunction

	function automatic void color_to_lab(input logic [7:0] r8, g8, b8, output longint lab[3]);
		longint unsigned lr, lg, lb;
		longint fx, fy, fz;
		lr = linear_light[r8];
		lg = linear_light[g8];
		lb = linear_light[b8];
		fx = lab_curve(tristimulus(28440, 24655, 12441, lr, lg, lb));
		fy = lab_curve(tristimulus(13938, 46868, 4730, lr, lg, lb));
		fz = lab_curve(tristimulus(1164, 7174, 57198, lr, lg, lb));
		lab[0] = 116 * fy - 16 * 65536;
		lab[1] = 500 * (fx - fy);
		lab[2] = 200 * (fy - fz);
	endfunction

	// Round the magnitude half away from zero, restore the sign, then clamp.
	function automatic longint round_clamp(input longint x, input longint lo, hi);
		longint m, v;
		m = (x < 0) ? -x : x;
		m = (m + (1 << (FracShift - 1))) >> FracShift;
		v = (x < 0) ? -m : m;
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned res, bit_pos;
		res = 0;
		bit_pos = 64'd1 << 62;
		while (bit_pos > n) bit_pos >>= 2;
		while (bit_pos != 0) begin
			if (n >= res + bit_pos) begin
				n -= res + bit_pos;
				res = (res >> 1) + bit_pos;
			end else begin
				res >>= 1;
			end
			bit_pos >>= 2;
		end
		return res;
	endfunction

	function automatic color_result_t predict_color_pair(input logic [7:0] r1, g1, b1,
			input logic [7:0] r2, g2, b2);
		longint p[3], q[3], d;
		longint unsigned sum;
		color_result_t res;
		color_to_lab(r1, g1, b1, p);
		color_to_lab(r2, g2, b2, q);
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			d = p[i] - q[i];
			if (d < 0) d = -d;
			sum += d * d;
		end
		res.lightness = 15'(round_clamp(p[0], 0, 32767));
		res.green_red = 16'(round_clamp(p[1], -32768, 32767));
		res.blue_yellow = 16'(round_clamp(p[2], -32768, 32767));
		res.span = 17'(round_clamp(longint'(int_sqrt(sum)), 0, 131071));
		return res;
	endfunction

	initial begin
		fail_count = 0;
		open_count = 0;
		for (int c = 0; c < 256; c++)
			linear_light[c] = (c <= 10) ? (c * 6553600) / 329460 : gamma_floor(c);
		for (int i = 0; i < CubeEntries; i++)
			cube_root_tab[i] = cube_root_floor(longint'(i) << (48 - CubeBits));
	end

	always @(posedge clk) begin
		color_result_t exp_res;
		if (arst_n) begin
			if (start && !busy)
				expected_colors.push_back(predict_color_pair(red_first, green_first,
					blue_first, red_second, green_second, blue_second));
			if (done) begin
				if (expected_colors.size() == 0) begin
					$display("%0t: result with no item pending: L=%0d a=%0d b=%0d dist=%0d",
						$time, lightness_first, green_red_axis_first,
						blue_yellow_axis_first, distance);
					fail_count++;
				end else begin
					exp_res = expected_colors.pop_front();
					if (lightness_first !== exp_res.lightness) begin
						$display("%0t: lightness expected %0d actual %0d", $time,
							exp_res.lightness, lightness_first);
						fail_count++;
					end
					if (green_red_axis_first !== exp_res.green_red) begin
						$display("%0t: green-red axis expected %0d actual %0d", $time,
							$signed(exp_res.green_red), green_red_axis_first);
						fail_count++;
					end
					if (blue_yellow_axis_first !== exp_res.blue_yellow) begin
						$display("%0t: blue-yellow axis expected %0d actual %0d", $time,
							$signed(exp_res.blue_yellow), blue_yellow_axis_first);
						fail_count++;
					end
					if (distance !== exp_res.span) begin
						$display("%0t: distance expected %0d actual %0d", $time,
							exp_res.span, distance);
						fail_count++;
					end
				end
			end
		end
		open_count = expected_colors.size();
	end

endmodule

FILE: verif/tb_srgb_lab_color_distance.sv
`timescale 1ns / 1ps

module tb_srgb_lab_color_distance;

	localparam int CycleLimit = 200000;
	localparam int DrainCycles = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [7:0] red_first = '0, green_first = '0, blue_first = '0;
	logic [7:0] red_second = '0, green_second = '0, blue_second = '0;
	logic done;
	logic [14:0] lightness_first;
	logic signed [15:0] green_red_axis_first;
	logic signed [15:0] blue_yellow_axis_first;
	logic [16:0] distance;
	int fail_count;
	int open_count;
	int cycle_count = 0;

	always #1 clk = ~clk;

	srgb_lab_color_distance DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.red_first(red_first), .green_first(green_first), .blue_first(blue_first),
		.red_second(red_second), .green_second(green_second), .blue_second(blue_second),
		.done(done), .lightness_first(lightness_first),
		.green_red_axis_first(green_red_axis_first),
		.blue_yellow_axis_first(blue_yellow_axis_first), .distance(distance)
	);

	srgb_lab_color_distance_checker color_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.red_first(red_first), .green_first(green_first), .blue_first(blue_first),
		.red_second(red_second), .green_second(green_second), .blue_second(blue_second),
		.done(done), .lightness_first(lightness_first),
		.green_red_axis_first(green_red_axis_first),
		.blue_yellow_axis_first(blue_yellow_axis_first), .distance(distance),
		.fail_count(fail_count), .open_count(open_count)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_pair(input logic [7:0] r1, g1, b1, r2, g2, b2, input int idle_pct);
		logic taken;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		{red_first, green_first, blue_first} <= {r1, g1, b1};
		{red_second, green_second, blue_second} <= {r2, g2, b2};
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic send_random(input int idle_pct);
		logic [7:0] c[6];
		for (int i = 0; i < 6; i++) begin
			case ($urandom_range(5))
				0: c[i] = 8'd0;
				1: c[i] = 8'd255;
				2: c[i] = 8'($urandom_range(12));
				default: c[i] = 8'($urandom);
			endcase
		end
		// Often make the second color a close neighbor so small distances are seen.
		if ($urandom_range(3) == 0)
			for (int i = 3; i < 6; i++) c[i] = c[i - 3] ^ 8'($urandom_range(3));
		send_pair(c[0], c[1], c[2], c[3], c[4], c[5], idle_pct);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (open_count != 0) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes: black, white, primaries, near-black linear segment, identical colors.
		send_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 0);
		send_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 0);
		send_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 0);
		send_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0);
		send_pair(8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 0);
		send_pair(8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 0);
		send_pair(8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 0);
		send_pair(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 0);
		send_pair(8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 0);
		send_pair(8'd0, 8'd0, 8'd1, 8'd10, 8'd10, 8'd10, 0);
		send_pair(8'd10, 8'd11, 8'd10, 8'd11, 8'd11, 8'd11, 0);
		send_pair(8'd2, 8'd3, 8'd4, 8'd128, 8'd128, 8'd128, 0);
		send_pair(8'd0, 8'd0, 8'd12, 8'd0, 8'd0, 8'd255, 0);
		send_pair(8'd170, 8'd85, 8'd170, 8'd85, 8'd170, 8'd85, 0);
		send_pair(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 0);
		send_pair(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 0);

		// Hold off until the pipeline is empty, then restart from idle.
		wait_drained();

		for (int i = 0; i < 600; i++) send_random(34);
		for (int i = 0; i < 600; i++) send_random(58);
		for (int i = 0; i < 650; i++) send_random(0);

		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
